@@ src/stxd_pkg.sv @@
// stxd_pkg: shared types, character codes and result codes for the stx/etx response deframer
// used by stxd_frame_fsm and stx_etx_response_deframer; depends on nothing else

package stxd_pkg;

	// default sizing
	localparam int CLASSIFY_WINDOW_DEF = 32;
	localparam int MAX_ID_DIGITS_DEF   = 19;

	// framing characters
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_FS    = 8'h1c;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_FRAME   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// response classes
	localparam logic [1:0] CLS_BULK = 2'd0;
	localparam logic [1:0] CLS_KV   = 2'd1;
	localparam logic [1:0] CLS_CSV  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_START    = 3'd1;
	localparam logic [2:0] ERR_ID       = 3'd2;
	localparam logic [2:0] ERR_NO_SEP   = 3'd3;
	localparam logic [2:0] ERR_EMPTY    = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ID      = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_DROP    = 3'd3,
		PH_SKIP    = 3'd4
	} phase_t;

	// one result of the frame logic towards the output register
	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [63:0] transaction_id;
		logic [1:0]  response_class;
		logic [2:0]  error_code;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// bytes that leave the class undecided
	function automatic logic is_plain(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)
			|| c == 8'h20 || c == 8'h22 || c == 8'h5f || c == 8'h2d;
	endfunction

endpackage

@@ src/stx_etx_response_deframer.sv @@
// stx_etx_response_deframer: top level, input register, frame logic and output register
// depends on stxd_pkg and stxd_frame_fsm
// path: an accepted byte is held in the input register, and its result in the output register
// throughput: one byte per cycle unless the output stalls; the frame logic between the input and
//   output registers is combinational, so only a stalled output with a result pending holds input
// reset: arst_n clears both register valids and returns the frame logic to waiting for stx

module stx_etx_response_deframer #(
	parameter int CLASSIFY_WINDOW = stxd_pkg::CLASSIFY_WINDOW_DEF,
	parameter int MAX_ID_DIGITS   = stxd_pkg::MAX_ID_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// received byte channel
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [63:0] transaction_id,
	output logic [1:0]  response_class,
	output logic [2:0]  error_code
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame logic result for the byte held in stage one
	stxd_pkg::result_t res;

	logic out_free;   // output register can take a transaction this cycle
	logic step;       // stage one byte is consumed by the frame logic
	logic rx_take;

	// output register
	logic              res_valid_q;
	stxd_pkg::result_t res_q;

	// a byte that yields no result never waits on the output side
	assign out_free = !res_valid_q || !res_stall;
	assign step     = valid_s1 && (!res.emit || out_free);
	assign rx_stall = valid_s1 && !step;
	assign rx_take  = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of stage one needs no reset
	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	stxd_frame_fsm #(
		.CLASSIFY_WINDOW (CLASSIFY_WINDOW),
		.MAX_ID_DIGITS   (MAX_ID_DIGITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// output register: loads when a result is produced, clears once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			res_q <= res;
		end
	end

	assign res_valid      = res_valid_q;
	assign kind           = res_q.kind;
	assign payload_byte   = res_q.payload_byte;
	assign transaction_id = res_q.transaction_id;
	assign response_class = res_q.response_class;
	assign error_code     = res_q.error_code;

endmodule

@@ src/stxd_frame_fsm.sv @@
// stxd_frame_fsm: frame state, id accumulation and payload classification, one byte per step
// depends on stxd_pkg

module stxd_frame_fsm #(
	parameter int CLASSIFY_WINDOW = stxd_pkg::CLASSIFY_WINDOW_DEF,
	parameter int MAX_ID_DIGITS   = stxd_pkg::MAX_ID_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output stxd_pkg::result_t   res
);

	localparam int PW = $clog2(CLASSIFY_WINDOW + 1);
	localparam int CW = $clog2(MAX_ID_DIGITS + 1);

	stxd_pkg::phase_t phase_q, phase_d;
	logic [63:0]      acc_q, acc_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [PW-1:0]    pos_q, pos_d;
	logic [1:0]       cls_q, cls_d;
	logic             dec_q, dec_d;
	logic [2:0]       err_q, err_d;

	logic [63:0] acc_next;
	logic        digit;

	assign digit    = stxd_pkg::is_digit(rx_byte);
	assign acc_next = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0}
		+ {60'd0, rx_byte[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stxd_pkg::PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			cls_q   <= stxd_pkg::CLS_BULK;
			dec_q   <= 1'b0;
			err_q   <= stxd_pkg::ERR_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			cls_q   <= cls_d;
			dec_q   <= dec_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		cls_d   = cls_q;
		dec_d   = dec_q;
		err_d   = err_q;
		res     = '0;
		unique case (phase_q)
			stxd_pkg::PH_ID: begin
				if (digit) begin
					if (cnt_q >= CW'(MAX_ID_DIGITS)) begin
						err_d   = stxd_pkg::ERR_ID;
						phase_d = stxd_pkg::PH_SKIP;
					end else begin
						acc_d = acc_next;
						cnt_d = cnt_q + CW'(1);
					end
				end else if (rx_byte == stxd_pkg::CH_FS && cnt_q != '0) begin
					phase_d = stxd_pkg::PH_PAYLOAD;
				end else begin
					err_d = (cnt_q == '0) ? stxd_pkg::ERR_ID : stxd_pkg::ERR_NO_SEP;
					if (rx_byte == stxd_pkg::CH_ETX) begin
						phase_d        = stxd_pkg::PH_IDLE;
						res.emit       = 1'b1;
						res.kind       = stxd_pkg::KIND_ERROR;
						res.error_code = err_d;
					end else begin
						phase_d = stxd_pkg::PH_SKIP;
					end
				end
			end
			stxd_pkg::PH_PAYLOAD: begin
				res.emit = 1'b1;
				if (rx_byte == stxd_pkg::CH_ETX) begin
					phase_d = stxd_pkg::PH_IDLE;
					if (pos_q == '0) begin
						res.kind       = stxd_pkg::KIND_ERROR;
						res.error_code = stxd_pkg::ERR_EMPTY;
					end else begin
						res.kind           = stxd_pkg::KIND_FRAME;
						res.transaction_id = acc_q;
						res.response_class = dec_q ? cls_q : stxd_pkg::CLS_BULK;
					end
				end else begin
					res.kind         = stxd_pkg::KIND_PAYLOAD;
					res.payload_byte = rx_byte;
					// classification over the opening window of the payload
					if (!dec_q && pos_q < PW'(CLASSIFY_WINDOW)) begin
						if (pos_q == '0) begin
							if (rx_byte == stxd_pkg::CH_EQ || rx_byte == stxd_pkg::CH_COMMA) begin
								cls_d = stxd_pkg::CLS_BULK;
								dec_d = 1'b1;
							end
						end else if (rx_byte == stxd_pkg::CH_EQ) begin
							cls_d = stxd_pkg::CLS_KV;
							dec_d = 1'b1;
						end else if (rx_byte == stxd_pkg::CH_COMMA
							|| rx_byte == stxd_pkg::CH_CR || rx_byte == stxd_pkg::CH_LF) begin
							cls_d = stxd_pkg::CLS_CSV;
							dec_d = 1'b1;
						end else if (!stxd_pkg::is_plain(rx_byte)) begin
							cls_d = stxd_pkg::CLS_BULK;
							dec_d = 1'b1;
						end
						pos_d = pos_q + PW'(1);
					end
				end
			end
			stxd_pkg::PH_SKIP: begin
				if (rx_byte == stxd_pkg::CH_ETX) begin
					phase_d        = stxd_pkg::PH_IDLE;
					res.emit       = 1'b1;
					res.kind       = stxd_pkg::KIND_ERROR;
					res.error_code = err_q;
				end
			end
			stxd_pkg::PH_DROP: begin
				if (rx_byte == stxd_pkg::CH_STX) begin
					phase_d = stxd_pkg::PH_ID;
					acc_d   = '0;
					cnt_d   = '0;
					pos_d   = '0;
					cls_d   = stxd_pkg::CLS_BULK;
					dec_d   = 1'b0;
					err_d   = stxd_pkg::ERR_NONE;
				end
			end
			default: begin
				if (rx_byte == stxd_pkg::CH_STX) begin
					phase_d = stxd_pkg::PH_ID;
					acc_d   = '0;
					cnt_d   = '0;
					pos_d   = '0;
					cls_d   = stxd_pkg::CLS_BULK;
					dec_d   = 1'b0;
					err_d   = stxd_pkg::ERR_NONE;
				end else begin
					phase_d        = stxd_pkg::PH_DROP;
					res.emit       = 1'b1;
					res.kind       = stxd_pkg::KIND_ERROR;
					res.error_code = stxd_pkg::ERR_START;
				end
			end
		endcase
	end

	a_payload_only_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.kind == stxd_pkg::KIND_PAYLOAD |-> phase_q == stxd_pkg::PH_PAYLOAD)
		else $error("payload transaction outside a frame payload");

	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.kind == stxd_pkg::KIND_ERROR |-> res.error_code != stxd_pkg::ERR_NONE)
		else $error("error transaction without an error code");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == stxd_pkg::PH_DROP && rx_byte != stxd_pkg::CH_STX
		|=> phase_q == stxd_pkg::PH_DROP)
		else $error("left drop phase without a start byte");

	a_digit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ID_DIGITS))
		else $error("id digit count beyond limit");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(CLASSIFY_WINDOW))
		else $error("payload position beyond classify window");

endmodule
